>>> design/free_list_block_allocator_assert.svh
// Assertion macros shared by the free list block allocator RTL.
`ifndef FREE_LIST_BLOCK_ALLOCATOR_ASSERT_SVH
`define FREE_LIST_BLOCK_ALLOCATOR_ASSERT_SVH

// Checks a condition at every clock edge outside reset.
`define FLBA_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Checks a consequence in the cycle after the antecedent holds.
`define FLBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/flba_pkg.sv
// Shared constants and types of the free list block allocator.
package flba_pkg;

	localparam int MAX_BLOCKS_DFLT = 1024;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_EMPTY    = 2'd1;
	localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

endpackage

>>> design/flba_ram.sv
// Generic single write port, single read port RAM with registered read data.
module flba_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

>>> design/free_list_block_allocator.sv
// Fixed-size block allocator with a LIFO free list held in a link RAM and an occupancy RAM.
// A command's result is registered as execute ends; execute stalls while a result waits.
// A new command is taken only in idle, set by the registered read of both RAMs.
// Reset or a pool_size write rebuilds the list at once: no RAM clearing pass is needed,
// because blocks at or above the fresh watermark are known free and link to their successor.
// A result waiting in the output register does not block the next input transfer.
module free_list_block_allocator import flba_pkg::*; #(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DFLT,
	localparam int IDX_W = $clog2(MAX_BLOCKS),
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1),
	localparam int S_DATA_W = ((IDX_W + 7) / 8) * 8,
	localparam int M_DATA_W = ((IDX_W + CNT_W + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CNT_W-1:0]    cfg_data,     // pool_size
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,      // block_index, zero padding
	input  logic [0:0]          s_tuser,      // command
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,      // granted_index, free_count, zero padding
	output logic [1:0]          m_tuser       // status
);

	state_t             state_q;
	logic               cmd_q;
	logic [IDX_W-1:0]   idx_q;
	logic [CNT_W-1:0]   pool_size_q;
	logic [IDX_W-1:0]   head_q;
	logic [CNT_W-1:0]   free_q;
	logic [CNT_W-1:0]   fresh_q;

	logic               out_valid_q;
	logic [1:0]         out_status_q;
	logic [IDX_W-1:0]   out_grant_q;
	logic [CNT_W-1:0]   out_count_q;

	logic               in_fire;
	logic               cfg_fire;
	logic               exec_fire;
	logic [CNT_W-1:0]   cfg_size;

	logic [IDX_W-1:0]   link_rdata;
	logic               occ_rdata;
	logic [IDX_W-1:0]   occ_raddr;

	logic [CNT_W-1:0]   head_inc;
	logic               head_fresh;
	logic               idx_occ;
	logic               idx_bad;

	logic [1:0]         res_status;
	logic [IDX_W-1:0]   res_grant;
	logic [IDX_W-1:0]   head_d;
	logic [CNT_W-1:0]   free_d;
	logic [CNT_W-1:0]   fresh_d;
	logic               link_we;
	logic               occ_we;
	logic [IDX_W-1:0]   occ_waddr;
	logic               occ_wdata;

	assign cfg_ready = (state_q == ST_IDLE);
	assign s_tready  = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign in_fire   = s_tvalid && s_tready;
	assign exec_fire = (state_q == ST_EXEC) && (!out_valid_q || m_tready);

	// A pool size of zero becomes one; anything beyond the RAM depth is clipped.
	always_comb begin
		cfg_size = cfg_data;
		if (cfg_data == '0) begin
			cfg_size = CNT_W'(1);
		end else if (cfg_data > CNT_W'(MAX_BLOCKS)) begin
			cfg_size = CNT_W'(MAX_BLOCKS);
		end
	end

	// Read addresses stay put during a stall, so the registered read data holds.
	assign occ_raddr = (state_q == ST_IDLE) ? s_tdata[IDX_W-1:0] : idx_q;

	flba_ram #(
		.WIDTH(IDX_W),
		.DEPTH(MAX_BLOCKS)
	) u_link_ram (
		.clk    (clk),
		.wr_en  (link_we && exec_fire),
		.wr_addr(idx_q),
		.wr_data(head_q),
		.rd_addr(head_q),
		.rd_data(link_rdata)
	);

	flba_ram #(
		.WIDTH(1),
		.DEPTH(MAX_BLOCKS)
	) u_occ_ram (
		.clk    (clk),
		.wr_en  (occ_we && exec_fire),
		.wr_addr(occ_waddr),
		.wr_data(occ_wdata),
		.rd_addr(occ_raddr),
		.rd_data(occ_rdata)
	);

	// Blocks at or above the watermark were never handed out since the last rebuild.
	assign head_inc   = CNT_W'(head_q) + CNT_W'(1);
	assign head_fresh = CNT_W'(head_q) >= fresh_q;
	assign idx_occ    = (CNT_W'(idx_q) < fresh_q) && occ_rdata;
	assign idx_bad    = (CNT_W'(idx_q) >= pool_size_q) || !idx_occ || (free_q >= pool_size_q);

	always_comb begin
		res_status = STATUS_OK;
		res_grant  = '0;
		head_d     = head_q;
		free_d     = free_q;
		fresh_d    = fresh_q;
		link_we    = 1'b0;
		occ_we     = 1'b0;
		occ_waddr  = head_q;
		occ_wdata  = 1'b0;
		if (cmd_q == CMD_ALLOC) begin
			if (free_q == '0) begin
				res_status = STATUS_EMPTY;
			end else begin
				res_grant = head_q;
				occ_we    = 1'b1;
				occ_waddr = head_q;
				occ_wdata = 1'b1;
				free_d    = free_q - CNT_W'(1);
				if (head_fresh) begin
					fresh_d = fresh_q + CNT_W'(1);
					head_d  = (head_inc < pool_size_q) ? head_inc[IDX_W-1:0] : '0;
				end else begin
					head_d = link_rdata;
				end
			end
		end else begin
			if (idx_bad) begin
				res_status = STATUS_BAD_FREE;
			end else begin
				occ_we    = 1'b1;
				occ_waddr = idx_q;
				occ_wdata = 1'b0;
				link_we   = 1'b1;
				head_d    = idx_q;
				free_d    = free_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pool_size_q <= CNT_W'(MAX_BLOCKS);
			head_q      <= '0;
			free_q      <= CNT_W'(MAX_BLOCKS);
			fresh_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cfg_fire) begin
				pool_size_q <= cfg_size;
				head_q      <= '0;
				free_q      <= cfg_size;
				fresh_q     <= '0;
			end else if (exec_fire) begin
				head_q  <= head_d;
				free_q  <= free_d;
				fresh_q <= fresh_d;
			end

			if (exec_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q <= s_tuser[0];
			idx_q <= s_tdata[IDX_W-1:0];
		end
		if (exec_fire) begin
			out_status_q <= res_status;
			out_grant_q  <= res_grant;
			out_count_q  <= free_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = M_DATA_W'({out_count_q, out_grant_q});

	`include "free_list_block_allocator_assert.svh"

	`FLBA_ASSERT_ALWAYS(a_free_le_size, free_q <= pool_size_q, "free count exceeds pool size")
	`FLBA_ASSERT_ALWAYS(a_fresh_le_size, fresh_q <= pool_size_q, "watermark exceeds pool size")
	`FLBA_ASSERT_NEXT(a_exec_to_out, exec_fire, m_tvalid && (state_q == ST_IDLE), "result not registered after execute")
	`FLBA_ASSERT_NEXT(a_alloc_dec, exec_fire && (cmd_q == CMD_ALLOC) && (free_q != '0), free_q == $past(free_q) - CNT_W'(1), "allocate did not take one free block")
	`FLBA_ASSERT_NEXT(a_cfg_rebuild, cfg_fire, (free_q == pool_size_q) && (fresh_q == '0) && (head_q == '0), "pool size write did not rebuild the list")

endmodule
